@@ sv/cursor_deque_list_manager_assert.svh @@
// Assertion helpers used by the controller of the cursor list manager.
`ifndef CURSOR_DEQUE_LIST_MANAGER_ASSERT_SVH
`define CURSOR_DEQUE_LIST_MANAGER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CDL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CDL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/cdl_pkg.sv @@
package cdl_pkg;

  typedef enum logic [4:0] {
    OP_CLEAR      = 5'd0,
    OP_INS_FIRST  = 5'd1,
    OP_INS_LAST   = 5'd2,
    OP_CUR_FIRST  = 5'd3,
    OP_CUR_LAST   = 5'd4,
    OP_RD_FIRST   = 5'd5,
    OP_RD_LAST    = 5'd6,
    OP_DEL_FIRST  = 5'd7,
    OP_DEL_LAST   = 5'd8,
    OP_DEL_AFTER  = 5'd9,
    OP_DEL_BEFORE = 5'd10,
    OP_INS_AFTER  = 5'd11,
    OP_INS_BEFORE = 5'd12,
    OP_RD_CUR     = 5'd13,
    OP_WR_CUR     = 5'd14,
    OP_NEXT       = 5'd15,
    OP_PREV       = 5'd16,
    OP_QUERY      = 5'd17
  } opcode_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load_in;
    logic rd_a;
    logic rd_b;
    logic wr_a;
    logic wr_b;
    logic load_out;
  } ctrl_cmd_t;

endpackage

@@ sv/cdl_cmd_if.sv @@
interface cdl_cmd_if;
  logic               valid;
  logic               ready;
  logic        [4:0]  opcode;
  logic signed [31:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

@@ sv/cdl_res_if.sv @@
interface cdl_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic               error;
  logic               cursor_active;

  modport source (output valid, output read_value, output error, output cursor_active,
                  input ready);
  modport sink (input valid, input read_value, input error, input cursor_active,
                output ready);
endinterface

@@ sv/cursor_deque_list_manager.sv @@
// Channel | Dir | Payload                              | Transfer when
// cmd_i   | in  | opcode[4:0], value[31:0]             | valid && ready
// res_o   | out | read_value[31:0], error, cursor_active | valid && ready
//
// Each command runs through one accept step, two synchronous reads of the slot
// memories (the entry, then the neighbor a cursor-side delete drops) and two write phases,
// set by the single write port of each link memory. The result is loaded from the last
// write phase, and no new command is accepted until then. A stalled result holds the
// block in its last write phase. Reset (rst_ni low, asynchronous) empties the list at
// once; the slot memories need no clearing pass.
module cursor_deque_list_manager #(
  parameter int CAPACITY = 256
) (
  input logic         clk_i,
  input logic         rst_ni,
  cdl_cmd_if.sink     cmd_i,
  cdl_res_if.source   res_o
);
  import cdl_pkg::*;

  ctrl_cmd_t ctrl_cmd;

  // Sequence accept, read, write and result load.
  cdl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .out_ready_i (res_o.ready),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (res_o.valid),
    .cmd_o       (ctrl_cmd)
  );

  // Hold slot table, list pointers and the result register.
  cdl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .opcode_i        (cmd_i.opcode),
    .value_i         (cmd_i.value),
    .read_value_o    (res_o.read_value),
    .error_o         (res_o.error),
    .cursor_active_o (res_o.cursor_active)
  );

endmodule

@@ sv/cdl_ctrl.sv @@
module cdl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_ready_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output cdl_pkg::ctrl_cmd_t cmd_o
);
  import cdl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD_A = 5'b00010,
    S_RD_B = 5'b00100,
    S_WR_A = 5'b01000,
    S_WR_B = 5'b10000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load_in  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.rd_a     = (state_q == S_RD_A);
    cmd_o.rd_b     = (state_q == S_RD_B);
    cmd_o.wr_a     = (state_q == S_WR_A);
    cmd_o.wr_b     = (state_q == S_WR_B);
    cmd_o.load_out = (state_q == S_WR_B) && out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_RD_A;
      S_RD_A: state_d = S_RD_B;
      S_RD_B: state_d = S_WR_A;
      S_WR_A: state_d = S_WR_B;
      S_WR_B: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`include "cursor_deque_list_manager_assert.svh"

  `CDL_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, state_q == S_RD_A)
  `CDL_ASSERT_NEXT(a_rd_a_to_rd_b, state_q == S_RD_A, state_q == S_RD_B)
  `CDL_ASSERT_NEXT(a_stall_holds, (state_q == S_WR_B) && out_valid_q && !out_ready_i,
                   state_q == S_WR_B)
  `CDL_ASSERT_IMPL(a_result_from_wr_b, $rose(out_valid_q), $past(state_q == S_WR_B))

endmodule

@@ sv/cdl_datapath.sv @@
module cdl_datapath #(
  parameter int CAPACITY = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cdl_pkg::ctrl_cmd_t cmd_i,
  input  logic        [4:0]  opcode_i,
  input  logic signed [31:0] value_i,
  output logic signed [31:0] read_value_o,
  output logic               error_o,
  output logic               cursor_active_o
);
  import cdl_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW = $clog2(CAPACITY + 1);
  localparam logic [PW-1:0] NIL = PW'(CAPACITY);

  logic [PW-1:0] nxt_mem [CAPACITY];
  logic [PW-1:0] prv_mem [CAPACITY];
  logic [31:0]   val_mem [CAPACITY];

  logic [PW-1:0] head_q, head_d, tail_q, tail_d, cur_q, cur_d;
  logic [PW-1:0] free_q, free_d, mark_q, mark_d;
  logic [4:0]    op_q;
  logic [31:0]   in_val_q;
  logic [PW-1:0] n1_q, p1_q, nb_q, pb_q;
  logic [31:0]   v1_q;
  logic [PW-1:0] a1, a2;

  logic          w1_nxt_we, w1_prv_we, w1_val_we;
  logic [PW-1:0] w1_nxt_addr, w1_prv_addr, w1_val_addr;
  logic [PW-1:0] w1_nxt_data, w1_prv_data;
  logic          w2_nxt_we_d, w2_prv_we_d, w2_nxt_we_q, w2_prv_we_q;
  logic [PW-1:0] w2_nxt_addr_d, w2_prv_addr_d, w2_nxt_addr_q, w2_prv_addr_q;
  logic [PW-1:0] w2_nxt_data_d, w2_prv_data_d, w2_nxt_data_q, w2_prv_data_q;

  logic          take_ok;
  logic [PW-1:0] take_slot, take_free, take_mark;
  logic          h_ok, t_ok, c_ok;
  logic [31:0]   res_rd_d, res_rd_q;
  logic          res_err_d, res_err_q;
  logic [31:0]   out_rd_q;
  logic          out_err_q, out_act_q;
  logic          nxt_we, prv_we;
  logic [AW-1:0] nxt_wa, prv_wa;
  logic [PW-1:0] nxt_wd, prv_wd;

  // First read address: the entry the command looks at.
  always_comb begin
    unique case (op_q)
      OP_RD_FIRST, OP_DEL_FIRST: a1 = head_q;
      OP_RD_LAST, OP_DEL_LAST:   a1 = tail_q;
      default:                   a1 = cur_q;
    endcase
  end

  // Second read address: the neighbor that a cursor-side delete drops.
  assign a2 = (op_q == OP_DEL_AFTER) ? n1_q : p1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q     <= opcode_i;
      in_val_q <= value_i;
    end
    if (cmd_i.rd_a) begin
      n1_q <= nxt_mem[a1[AW-1:0]];
      p1_q <= prv_mem[a1[AW-1:0]];
      v1_q <= val_mem[a1[AW-1:0]];
      nb_q <= nxt_mem[free_q[AW-1:0]];
    end
    if (cmd_i.rd_b && (op_q == OP_DEL_AFTER || op_q == OP_DEL_BEFORE)) begin
      nb_q <= nxt_mem[a2[AW-1:0]];
      pb_q <= prv_mem[a2[AW-1:0]];
    end
  end

  assign h_ok = head_q < NIL;
  assign t_ok = tail_q < NIL;
  assign c_ok = cur_q < NIL;

  // Slot allocation: free chain first, then the never-used watermark.
  always_comb begin
    take_ok   = 1'b1;
    take_slot = free_q;
    take_free = nb_q;
    take_mark = mark_q;
    if (!(free_q < NIL)) begin
      take_slot = mark_q;
      take_free = free_q;
      take_mark = mark_q + PW'(1);
      take_ok   = mark_q < NIL;
    end
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cur_d  = cur_q;
    free_d = free_q;
    mark_d = mark_q;
    res_rd_d  = '0;
    res_err_d = 1'b0;
    w1_nxt_we = 1'b0; w1_nxt_addr = take_slot; w1_nxt_data = NIL;
    w1_prv_we = 1'b0; w1_prv_addr = take_slot; w1_prv_data = NIL;
    w1_val_we = 1'b0; w1_val_addr = take_slot;
    w2_nxt_we_d = 1'b0; w2_nxt_addr_d = take_slot; w2_nxt_data_d = NIL;
    w2_prv_we_d = 1'b0; w2_prv_addr_d = take_slot; w2_prv_data_d = NIL;
    unique case (op_q)
      OP_CLEAR: begin
        head_d = NIL; tail_d = NIL; cur_d = NIL; free_d = NIL; mark_d = '0;
      end
      OP_INS_FIRST: begin
        if (!take_ok) res_err_d = 1'b1;
        else begin
          free_d = take_free; mark_d = take_mark;
          w1_val_we = 1'b1;
          w1_nxt_we = 1'b1; w1_nxt_data = head_q;
          w1_prv_we = 1'b1;
          if (h_ok) begin
            w2_prv_we_d = 1'b1; w2_prv_addr_d = head_q; w2_prv_data_d = take_slot;
          end else tail_d = take_slot;
          head_d = take_slot;
        end
      end
      OP_INS_LAST: begin
        if (!take_ok) res_err_d = 1'b1;
        else begin
          free_d = take_free; mark_d = take_mark;
          w1_val_we = 1'b1;
          w1_prv_we = 1'b1; w1_prv_data = tail_q;
          w1_nxt_we = 1'b1;
          if (t_ok) begin
            w2_nxt_we_d = 1'b1; w2_nxt_addr_d = tail_q; w2_nxt_data_d = take_slot;
          end else head_d = take_slot;
          tail_d = take_slot;
        end
      end
      OP_CUR_FIRST: cur_d = head_q;
      OP_CUR_LAST:  cur_d = tail_q;
      OP_RD_FIRST: begin
        if (h_ok) res_rd_d = v1_q;
        else res_err_d = 1'b1;
      end
      OP_RD_LAST: begin
        if (h_ok && t_ok) res_rd_d = v1_q;
        else res_err_d = 1'b1;
      end
      OP_DEL_FIRST: begin
        if (h_ok) begin
          if (cur_q == head_q) cur_d = NIL;
          head_d = n1_q;
          if (n1_q < NIL) begin
            w1_prv_we = 1'b1; w1_prv_addr = n1_q; w1_prv_data = NIL;
          end else tail_d = NIL;
          w1_nxt_we = 1'b1; w1_nxt_addr = head_q; w1_nxt_data = free_q;
          free_d = head_q;
        end
      end
      OP_DEL_LAST: begin
        if (t_ok) begin
          if (cur_q == tail_q) cur_d = NIL;
          tail_d = p1_q;
          if (p1_q < NIL) begin
            w1_nxt_we = 1'b1; w1_nxt_addr = p1_q; w1_nxt_data = NIL;
          end else head_d = NIL;
          w2_nxt_we_d = 1'b1; w2_nxt_addr_d = tail_q; w2_nxt_data_d = free_q;
          free_d = tail_q;
        end
      end
      OP_DEL_AFTER: begin
        if (c_ok && cur_q != tail_q && n1_q < NIL) begin
          w1_nxt_we = 1'b1; w1_nxt_addr = cur_q; w1_nxt_data = nb_q;
          if (nb_q < NIL) begin
            w1_prv_we = 1'b1; w1_prv_addr = nb_q; w1_prv_data = cur_q;
          end else tail_d = cur_q;
          w2_nxt_we_d = 1'b1; w2_nxt_addr_d = n1_q; w2_nxt_data_d = free_q;
          free_d = n1_q;
        end
      end
      OP_DEL_BEFORE: begin
        if (c_ok && cur_q != head_q && p1_q < NIL) begin
          w1_prv_we = 1'b1; w1_prv_addr = cur_q; w1_prv_data = pb_q;
          if (pb_q < NIL) begin
            w1_nxt_we = 1'b1; w1_nxt_addr = pb_q; w1_nxt_data = cur_q;
          end else head_d = cur_q;
          w2_nxt_we_d = 1'b1; w2_nxt_addr_d = p1_q; w2_nxt_data_d = free_q;
          free_d = p1_q;
        end
      end
      OP_INS_AFTER: begin
        if (c_ok) begin
          if (!take_ok) res_err_d = 1'b1;
          else begin
            free_d = take_free; mark_d = take_mark;
            w1_val_we = 1'b1;
            w1_prv_we = 1'b1; w1_prv_data = cur_q;
            w1_nxt_we = 1'b1; w1_nxt_data = n1_q;
            w2_nxt_we_d = 1'b1; w2_nxt_addr_d = cur_q; w2_nxt_data_d = take_slot;
            if (cur_q == tail_q) tail_d = take_slot;
            else if (n1_q < NIL) begin
              w2_prv_we_d = 1'b1; w2_prv_addr_d = n1_q; w2_prv_data_d = take_slot;
            end
          end
        end
      end
      OP_INS_BEFORE: begin
        if (c_ok) begin
          if (!take_ok) res_err_d = 1'b1;
          else begin
            free_d = take_free; mark_d = take_mark;
            w1_val_we = 1'b1;
            w1_nxt_we = 1'b1; w1_nxt_data = cur_q;
            w1_prv_we = 1'b1; w1_prv_data = p1_q;
            w2_prv_we_d = 1'b1; w2_prv_addr_d = cur_q; w2_prv_data_d = take_slot;
            if (cur_q == head_q) head_d = take_slot;
            else if (p1_q < NIL) begin
              w2_nxt_we_d = 1'b1; w2_nxt_addr_d = p1_q; w2_nxt_data_d = take_slot;
            end
          end
        end
      end
      OP_RD_CUR: begin
        if (c_ok) res_rd_d = v1_q;
        else res_err_d = 1'b1;
      end
      OP_WR_CUR: begin
        if (c_ok) begin
          w1_val_we = 1'b1; w1_val_addr = cur_q;
        end
      end
      OP_NEXT: if (c_ok) cur_d = (cur_q == tail_q) ? NIL : n1_q;
      OP_PREV: if (c_ok) cur_d = (cur_q == head_q) ? NIL : p1_q;
      default: ;
    endcase
  end

  // Link write ports: first write phase from the plan, second from its register.
  always_comb begin
    nxt_we = 1'b0; nxt_wa = w2_nxt_addr_q[AW-1:0]; nxt_wd = w2_nxt_data_q;
    prv_we = 1'b0; prv_wa = w2_prv_addr_q[AW-1:0]; prv_wd = w2_prv_data_q;
    if (cmd_i.wr_a) begin
      nxt_we = w1_nxt_we; nxt_wa = w1_nxt_addr[AW-1:0]; nxt_wd = w1_nxt_data;
      prv_we = w1_prv_we; prv_wa = w1_prv_addr[AW-1:0]; prv_wd = w1_prv_data;
    end else if (cmd_i.wr_b) begin
      nxt_we = w2_nxt_we_q;
      prv_we = w2_prv_we_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (cmd_i.wr_a && w1_val_we) val_mem[w1_val_addr[AW-1:0]] <= in_val_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      w2_nxt_addr_q <= w2_nxt_addr_d;
      w2_nxt_data_q <= w2_nxt_data_d;
      w2_prv_addr_q <= w2_prv_addr_d;
      w2_prv_data_q <= w2_prv_data_d;
      res_rd_q      <= res_rd_d;
      res_err_q     <= res_err_d;
    end
    if (cmd_i.load_out) begin
      out_rd_q  <= res_rd_q;
      out_err_q <= res_err_q;
      out_act_q <= cur_q < NIL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= NIL;
      tail_q      <= NIL;
      cur_q       <= NIL;
      free_q      <= NIL;
      mark_q      <= '0;
      w2_nxt_we_q <= 1'b0;
      w2_prv_we_q <= 1'b0;
    end else if (cmd_i.wr_a) begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      cur_q       <= cur_d;
      free_q      <= free_d;
      mark_q      <= mark_d;
      w2_nxt_we_q <= w2_nxt_we_d;
      w2_prv_we_q <= w2_prv_we_d;
    end
  end

  assign read_value_o    = out_rd_q;
  assign error_o         = out_err_q;
  assign cursor_active_o = out_act_q;

endmodule
